// ===== rtl/sspf_pkg.sv =====
// ----------------------------------------------------------------------------
// sspf_pkg
// Shared types and constants of the sensor sample packet framer: beat
// layouts, opcodes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sspf_pkg;

    // packet geometry
    localparam int PACKET_BYTES  = 256;
    localparam int MAX_WORDS     = 32;
    localparam int EMPTY_LEN     = 4;   // packet header only
    localparam int PKT_HDR_BYTES = 8;   // packet header plus base timestamp
    localparam int ENTRY_HDR     = 3;   // id, delta, size
    localparam int BYTE_MAX      = 255;

    localparam int LEN_W  = $clog2(PACKET_BYTES + 1);
    localparam int ADDR_W = $clog2(PACKET_BYTES);
    localparam int SUM_W  = $clog2(PACKET_BYTES + ENTRY_HDR + BYTE_MAX + 2);
    localparam int WORD_W = $clog2(MAX_WORDS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = CFG_IDX_W'(1);
    localparam logic [31:0]          AGE_RESET     = 32'd100;

    typedef enum logic [1:0] {
        OP_HDR   = 2'd0,
        OP_DATA  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_SEND  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  src_id;
        logic [31:0] sample_time_ms;
        logic [7:0]  sample_size;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic        send_ok;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  out_count;
        logic        out_last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DECIDE,
        ST_ENTRY_ID,
        ST_ENTRY_DELTA,
        ST_ENTRY_SIZE,
        ST_EMIT_CAP,
        ST_EMIT_PUSH
    } t_state;

    typedef struct packed {
        logic take;       // input beat accepted
        logic fill_step;  // zero one missing payload byte
        logic discard;    // drop an oversized first sample
        logic first;      // first sample opens the packet
        logic wr_id;
        logic wr_delta;
        logic wr_size;    // also commits the entry
        logic capture;    // move one packet byte into the word buffer
        logic push;       // hand the word buffer to the output register
    } t_cmd;

    typedef struct packed {
        logic gap;          // current sample is short of payload
        logic has_samples;
        logic fill_last;
        logic close;
        logic oversize;
        logic word_done;
        logic last_word;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/sspf_ram.sv =====
// ----------------------------------------------------------------------------
// sspf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sspf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sspf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sspf_ctrl
// Controller of the framer: sequences header handling, gap filling, entry
// writes and packet emission.
// ----------------------------------------------------------------------------
module sspf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sspf_pkg::t_op i_op,
    input  sspf_pkg::t_stat i_stat,
    output sspf_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import sspf_pkg::*;

    t_state r_state, n_state;
    logic   r_pend, n_pend;   // a sample header waits behind fill or emission
    logic   take;

    assign take       = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    case (i_op)
                        OP_HDR: begin
                            n_pend  = 1'b1;
                            n_state = i_stat.gap ? ST_FILL : ST_DECIDE;
                        end
                        OP_FLUSH: begin
                            if (i_stat.has_samples) begin
                                n_state = i_stat.gap ? ST_FILL : ST_EMIT_CAP;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (i_stat.fill_last) begin
                    n_state = r_pend ? ST_DECIDE : ST_EMIT_CAP;
                end
            end
            ST_DECIDE: begin
                if (i_stat.has_samples && i_stat.close) begin
                    n_state = ST_EMIT_CAP;
                end else if (!i_stat.has_samples && i_stat.oversize) begin
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_ENTRY_ID;
                end
            end
            ST_ENTRY_ID:    n_state = ST_ENTRY_DELTA;
            ST_ENTRY_DELTA: n_state = ST_ENTRY_SIZE;
            ST_ENTRY_SIZE:  n_state = ST_IDLE;
            ST_EMIT_CAP: begin
                if (i_stat.word_done) begin
                    n_state = ST_EMIT_PUSH;
                end
            end
            ST_EMIT_PUSH: begin
                if (i_stat.out_free) begin
                    if (i_stat.last_word) begin
                        n_state = r_pend ? ST_DECIDE : ST_IDLE;
                    end else begin
                        n_state = ST_EMIT_CAP;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.take = take;
        case (r_state)
            ST_FILL:        o_cmd.fill_step = 1'b1;
            ST_DECIDE: begin
                if (!i_stat.has_samples) begin
                    o_cmd.discard = i_stat.oversize;
                    o_cmd.first   = !i_stat.oversize;
                end
            end
            ST_ENTRY_ID:    o_cmd.wr_id    = 1'b1;
            ST_ENTRY_DELTA: o_cmd.wr_delta = 1'b1;
            ST_ENTRY_SIZE:  o_cmd.wr_size  = 1'b1;
            ST_EMIT_CAP:    o_cmd.capture  = 1'b1;
            ST_EMIT_PUSH:   o_cmd.push     = i_stat.out_free;
            default:        o_cmd.take     = take;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

// ===== rtl/sspf_dpath.sv =====
// ----------------------------------------------------------------------------
// sspf_dpath
// Datapath of the framer: packet store, packet bookkeeping, close checks,
// word assembly and the output register.
// ----------------------------------------------------------------------------
module sspf_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sspf_pkg::t_in_item               i_in_data,
    input  sspf_pkg::t_cmd                   i_cmd,
    output sspf_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [sspf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sspf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sspf_pkg::t_out_item              o_out_data
);
    import sspf_pkg::*;

    // packet bookkeeping
    logic [LEN_W-1:0]  r_len, n_len;
    logic [7:0]        r_samples, n_samples;
    logic [31:0]       r_base, n_base;
    logic [15:0]       r_seq, n_seq;
    logic [7:0]        r_rem, n_rem;
    logic              r_disc, n_disc;
    logic [31:0]       r_age, n_age;

    // held sample header
    logic [7:0]        r_h_id, n_h_id;
    logic [31:0]       r_h_t, n_h_t;
    logic [7:0]        r_h_size, n_h_size;
    logic [31:0]       r_h_now, n_h_now;

    // emission
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_words, n_words;
    logic [63:0]       r_buf, n_buf;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // store ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        ram_q;

    logic [ADDR_W-1:0] gap_addr;
    logic [31:0]       diff_t;
    logic [31:0]       age_now;
    logic [SUM_W-1:0]  grown_len;
    logic [SUM_W-1:0]  first_len;
    logic [7:0]        hdr_byte;
    logic [7:0]        pkt_byte;
    logic [3:0]        word_cnt;

    assign gap_addr  = ADDR_W'(r_len - LEN_W'(r_rem));
    assign diff_t    = r_h_t - r_base;
    assign age_now   = r_h_now - r_base;
    assign grown_len = SUM_W'(r_len) + SUM_W'(ENTRY_HDR) + SUM_W'(r_h_size);
    assign first_len = SUM_W'(PKT_HDR_BYTES + ENTRY_HDR) + SUM_W'(r_h_size);
    assign word_cnt  = (r_pos[2:0] == 3'd0) ? 4'd8 : {1'b0, r_pos[2:0]};

    always_comb begin
        case (r_pos[2:0])
            3'd0:    hdr_byte = r_seq[7:0];
            3'd1:    hdr_byte = r_seq[15:8];
            3'd2:    hdr_byte = r_samples;
            3'd4:    hdr_byte = r_base[7:0];
            3'd5:    hdr_byte = r_base[15:8];
            3'd6:    hdr_byte = r_base[23:16];
            3'd7:    hdr_byte = r_base[31:24];
            default: hdr_byte = 8'd0;
        endcase
    end

    assign pkt_byte = (r_pos[LEN_W-1:3] == '0) ? hdr_byte : ram_q;

    // status to the controller
    always_comb begin
        o_stat.gap         = (r_rem != 8'd0) && !r_disc;
        o_stat.has_samples = (r_samples != 8'd0);
        o_stat.fill_last   = (r_rem == 8'd1);
        o_stat.close       = (diff_t[31:8] != 24'd0)
                          || (grown_len > SUM_W'(PACKET_BYTES))
                          || (age_now >= r_age);
        o_stat.oversize    = (first_len > SUM_W'(PACKET_BYTES));
        o_stat.word_done   = (r_pos[2:0] == 3'd7) || ((r_pos + LEN_W'(1)) == r_len);
        o_stat.last_word   = (r_pos == r_len) || (r_words == WORD_W'(MAX_WORDS - 1));
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_len       = r_len;
        n_samples   = r_samples;
        n_base      = r_base;
        n_seq       = r_seq;
        n_rem       = r_rem;
        n_disc      = r_disc;
        n_age       = r_age;
        n_h_id      = r_h_id;
        n_h_t       = r_h_t;
        n_h_size    = r_h_size;
        n_h_now     = r_h_now;
        n_pos       = r_pos;
        n_words     = r_words;
        n_buf       = r_buf;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = gap_addr;
        wr_data     = 8'd0;

        if (i_cmd.take) begin
            case (i_in_data.op)
                OP_HDR: begin
                    n_h_id   = i_in_data.src_id;
                    n_h_t    = i_in_data.sample_time_ms;
                    n_h_size = i_in_data.sample_size;
                    n_h_now  = i_in_data.now_ms;
                    // a dropped sample ends here; a short one is zero filled
                    if (r_disc) begin
                        n_rem  = 8'd0;
                        n_disc = 1'b0;
                    end
                end
                OP_DATA: begin
                    if (r_rem != 8'd0) begin
                        if (!r_disc) begin
                            wr_en   = 1'b1;
                            wr_data = i_in_data.data_byte;
                        end
                        n_rem = r_rem - 8'd1;
                        if (r_rem == 8'd1) begin
                            n_disc = 1'b0;
                        end
                    end
                end
                OP_FLUSH: begin
                    if (r_samples == 8'd0) begin
                        n_rem  = 8'd0;
                        n_disc = 1'b0;
                    end
                end
                OP_SEND: begin
                    if (i_in_data.send_ok) begin
                        n_seq = r_seq + 16'd1;
                    end
                end
                default: n_seq = r_seq;
            endcase
        end

        if (i_cmd.fill_step) begin
            wr_en = 1'b1;
            n_rem = r_rem - 8'd1;
        end

        if (i_cmd.discard) begin
            n_rem  = r_h_size;
            n_disc = 1'b1;
        end

        if (i_cmd.first) begin
            n_base = r_h_t;
            n_len  = LEN_W'(PKT_HDR_BYTES);
        end

        if (i_cmd.wr_id) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(r_len);
            wr_data = r_h_id;
        end
        if (i_cmd.wr_delta) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(r_len + LEN_W'(1));
            wr_data = diff_t[7:0];
        end
        if (i_cmd.wr_size) begin
            wr_en     = 1'b1;
            wr_addr   = ADDR_W'(r_len + LEN_W'(2));
            wr_data   = r_h_size;
            n_len     = r_len + LEN_W'(ENTRY_HDR) + LEN_W'(r_h_size);
            n_samples = r_samples + 8'd1;
            n_rem     = r_h_size;
            n_disc    = 1'b0;
        end

        if (i_cmd.capture) begin
            n_buf[{r_pos[2:0], 3'b000} +: 8] = pkt_byte;
            n_pos = r_pos + LEN_W'(1);
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.push) begin
            n_out.out_word  = r_buf;
            n_out.out_count = word_cnt;
            n_out.out_last  = o_stat.last_word;
            n_out_valid     = 1'b1;
            n_buf           = 64'd0;
            n_words         = r_words + WORD_W'(1);
            if (o_stat.last_word) begin
                n_pos     = '0;
                n_words   = '0;
                n_len     = LEN_W'(EMPTY_LEN);
                n_samples = 8'd0;
                n_rem     = 8'd0;
                n_disc    = 1'b0;
            end
        end

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_AGE_LIMIT) begin
                n_age = i_cfg_data;
            end else if (i_cfg_idx == CFG_START_SEQ) begin
                n_seq = i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_W'(EMPTY_LEN);
            r_samples   <= 8'd0;
            r_base      <= 32'd0;
            r_seq       <= 16'd0;
            r_rem       <= 8'd0;
            r_disc      <= 1'b0;
            r_age       <= AGE_RESET;
            r_pos       <= '0;
            r_words     <= '0;
            r_buf       <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_samples   <= n_samples;
            r_base      <= n_base;
            r_seq       <= n_seq;
            r_rem       <= n_rem;
            r_disc      <= n_disc;
            r_age       <= n_age;
            r_pos       <= n_pos;
            r_words     <= n_words;
            r_buf       <= n_buf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_id   <= n_h_id;
        r_h_t    <= n_h_t;
        r_h_size <= n_h_size;
        r_h_now  <= n_h_now;
        r_out    <= n_out;
    end

    // read address follows the next position so data lines up with capture
    sspf_ram #(
        .DATA_W (8),
        .DEPTH  (PACKET_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (ADDR_W'(n_pos)),
        .o_rdata (ram_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/sensor_sample_packet_framer_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_sample_packet_framer_unit
// Packs sensor samples (header beat plus payload beats) into packets with a
// sequence/count header and base timestamp, and streams closed packets out
// as 64-bit words.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              beat
//  -------   ---------  ---------------------  ---------------------------------
//  in        sink       i_in_valid/o_in_stall  t_in_item: op, sample header,
//                                              payload byte, time, send outcome
//  out       source     o_out_valid/i_out_stall t_out_item: word, count, last
//  cfg       sink       i_cfg_we               index/data, write only
//
//  payload byte, send outcome and flush of an empty packet: taken back to
//    back, without stalling the input
//  sample header: taken, then a zero-fill step per payload byte missing from a
//    cut-short previous sample, a decide step and three entry writes (id,
//    delta, size); a header that closes the packet decides again after the
//    emission, and a dropped oversized sample skips the entry writes
//  packet emission: one capture per packet byte plus one push per word, paced
//    by the single read port of the packet store; output stall holds the push
//  reset is synchronous; the packet store needs no clearing as every byte is
//    written before it is read
//  while a header, flush or emission is in progress the input is stalled
//
module sensor_sample_packet_framer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sspf_pkg::t_in_item               i_in_data,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sspf_pkg::t_out_item              o_out_data,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [sspf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sspf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sspf_pkg::*;

    t_cmd  cmd;    // controller to datapath
    t_stat stat;   // datapath to controller

    // sequencing of headers, gap fill, entry writes and emission
    sspf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // packet store, bookkeeping and word assembly
    sspf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // payload bytes and send outcomes never hold up the next beat
    a_short_ops_no_stall : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall
            && (i_in_data.op == OP_DATA || i_in_data.op == OP_SEND))
        |=> !o_in_stall
    ) else $error("stall after payload byte or send outcome");

    // only a header or a flush can start a busy period
    a_stall_cause : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall)
        |-> $past(i_in_valid)
            && ($past(i_in_data.op) == OP_HDR || $past(i_in_data.op) == OP_FLUSH)
    ) else $error("input stalled without header or flush");

    // words are produced only during emission, never from the idle state
    a_word_from_emission : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("output word appeared outside emission");

endmodule

// ===== bench/sensor_sample_packet_framer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_sample_packet_framer_unit_test
// Self-checking bench for the packet framer: a directed opening run, then
// random sample traffic under several register settings. A scoreboard class
// mirrors the packet buffer, queues the packet words every accepted beat
// should produce and compares each output beat against them.
// ----------------------------------------------------------------------------
module sensor_sample_packet_framer_unit_test;
    import sspf_pkg::*;

    class packet_scoreboard;
        logic [7:0]  pkt_bytes [PACKET_BYTES];
        int unsigned pkt_len;
        int unsigned n_samples;
        int unsigned bytes_left;
        bit          dropping;
        logic [31:0] base_ms;
        logic [31:0] age_limit;
        logic [15:0] seq_no;
        t_out_item   words_due [$];
        int          errors;

        function new();
            foreach (pkt_bytes[i]) pkt_bytes[i] = 8'h00;
            base_ms   = '0;
            seq_no    = '0;
            age_limit = AGE_RESET;
            errors    = 0;
            empty_packet();
        endfunction

        function void empty_packet();
            pkt_len    = EMPTY_LEN;
            n_samples  = 0;
            bytes_left = 0;
            dropping   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_AGE_LIMIT) begin
                age_limit = data;
            end else if (idx == CFG_START_SEQ) begin
                seq_no = data[15:0];
            end
        endfunction

        // sequence and sample count bytes are filled in at close, then the buffer is cut into words
        function void ship_packet();
            int unsigned len;
            int unsigned pos;
            int unsigned cnt;
            int unsigned n;
            t_out_item   w;
            len = (pkt_len > PACKET_BYTES) ? PACKET_BYTES : pkt_len;
            pkt_bytes[0] = seq_no[7:0];
            pkt_bytes[1] = seq_no[15:8];
            pkt_bytes[2] = n_samples[7:0];
            pkt_bytes[3] = 8'h00;
            pos = 0;
            n   = 0;
            while (pos < len && n < MAX_WORDS) begin
                cnt = (len - pos > 8) ? 8 : len - pos;
                w = '0;
                for (int i = 0; i < cnt; i++) w.out_word[8*i +: 8] = pkt_bytes[pos + i];
                pos += cnt;
                w.out_count = cnt[3:0];
                w.out_last  = (pos >= len || n == MAX_WORDS - 1);
                words_due.push_back(w);
                n++;
            end
            empty_packet();
        endfunction

        function void take_beat(t_in_item it);
            logic [31:0] delta;
            logic [31:0] age;
            int unsigned at;
            case (it.op)
                OP_HDR: begin
                    bytes_left = 0;
                    dropping   = 1'b0;
                    delta = it.sample_time_ms - base_ms;
                    age   = it.now_ms - base_ms;
                    if (n_samples > 0 && (delta > BYTE_MAX
                            || pkt_len + ENTRY_HDR + it.sample_size > PACKET_BYTES
                            || age >= age_limit)) begin
                        ship_packet();
                    end
                    if (n_samples == 0
                            && PKT_HDR_BYTES + ENTRY_HDR + it.sample_size > PACKET_BYTES) begin
                        // first sample can never fit: swallow its payload
                        dropping   = 1'b1;
                        bytes_left = it.sample_size;
                    end else begin
                        if (n_samples == 0) begin
                            base_ms = it.sample_time_ms;
                            for (int i = 0; i < 4; i++) begin
                                pkt_bytes[4 + i] = it.sample_time_ms[8*i +: 8];
                            end
                            pkt_len = PKT_HDR_BYTES;
                        end
                        delta = it.sample_time_ms - base_ms;
                        pkt_bytes[pkt_len]     = it.src_id;
                        pkt_bytes[pkt_len + 1] = delta[7:0];
                        pkt_bytes[pkt_len + 2] = it.sample_size;
                        for (int i = 0; i < it.sample_size; i++) begin
                            pkt_bytes[pkt_len + ENTRY_HDR + i] = 8'h00;
                        end
                        pkt_len   += ENTRY_HDR + it.sample_size;
                        n_samples += 1;
                        bytes_left = it.sample_size;
                    end
                end
                OP_DATA: begin
                    if (bytes_left > 0) begin
                        if (!dropping) begin
                            at = pkt_len - bytes_left;
                            if (at < PACKET_BYTES) pkt_bytes[at] = it.data_byte;
                        end
                        bytes_left -= 1;
                        if (bytes_left == 0) dropping = 1'b0;
                    end
                end
                OP_FLUSH: begin
                    if (n_samples > 0) ship_packet();
                    else empty_packet();
                end
                OP_SEND: begin
                    if (it.send_ok) seq_no = seq_no + 16'd1;
                end
            endcase
        endfunction

        function void check_word(t_out_item got);
            t_out_item want;
            if (words_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat: expected none, got word %h count %0d last %0b",
                         $time, got.out_word, got.out_count, got.out_last);
            end else begin
                want = words_due.pop_front();
                if (got.out_word !== want.out_word) begin
                    errors++;
                    $display("%0t: out_word expected %h got %h", $time, want.out_word, got.out_word);
                end
                if (got.out_count !== want.out_count) begin
                    errors++;
                    $display("%0t: out_count expected %0d got %0d",
                             $time, want.out_count, got.out_count);
                end
                if (got.out_last !== want.out_last) begin
                    errors++;
                    $display("%0t: out_last expected %0b got %0b",
                             $time, want.out_last, got.out_last);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 4000000;
    // after the last word the block may still be chewing on a header:
    // a zero-fill step per missing payload byte, then the entry writes
    localparam int SETTLE_CYCLES = 320;
    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit                    tx_calm   = 1'b0;
    bit                    rx_calm   = 1'b0;
    int unsigned           cycles    = 0;
    packet_scoreboard      sb;

    sensor_sample_packet_framer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // watchdog, generous against the slowest legal run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[sensor_sample_packet_framer_unit] ERROR");
            $finish;
        end
    end

    // every accepted output beat goes straight to the scoreboard
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    end

    // receiver: a random hold-off before each word, with calm stretches
    initial begin
        int k;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            k = rx_calm ? 0 : $urandom_range(0, 18);
            if (k > 0) begin
                out_stall = 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // beat with every field random, the caller overrides what matters
    function automatic t_in_item noise_beat(t_op op);
        t_in_item it;
        it.op             = op;
        it.src_id         = 8'($urandom_range(0, 255));
        it.sample_time_ms = $urandom;
        it.sample_size    = 8'($urandom_range(0, 255));
        it.data_byte      = 8'($urandom_range(0, 255));
        it.now_ms         = $urandom;
        it.send_ok        = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    // with valid still up so a back-to-back beat needs no toggle
    task automatic drive_beat(t_in_item it);
        int gap;
        if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.take_beat(it);
        @(negedge clk);
    endtask

    task automatic send_header(logic [7:0] id, logic [31:0] t, logic [7:0] size,
                               logic [31:0] now);
        t_in_item it;
        it = noise_beat(OP_HDR);
        it.src_id         = id;
        it.sample_time_ms = t;
        it.sample_size    = size;
        it.now_ms         = now;
        drive_beat(it);
    endtask

    task automatic send_data(logic [7:0] b);
        t_in_item it;
        it = noise_beat(OP_DATA);
        it.data_byte = b;
        drive_beat(it);
    endtask

    task automatic send_ctrl(t_op op, logic ok);
        t_in_item it;
        it = noise_beat(op);
        it.send_ok = ok;
        drive_beat(it);
    endtask

    // hold the sender until every queued word has come out
    task automatic drain();
        in_valid = 1'b0;
        while (sb.words_due.size() != 0) @(negedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly well-formed samples (header then its payload) with a timeline
    // that usually stays within the delta range, plus flushes, send reports,
    // cut-short samples, stray bytes and pure noise
    task automatic run_traffic(int n_items);
        int          sent;
        int          kind;
        int          pick;
        int          size;
        int          keep;
        logic [31:0] clock_ms;
        logic [31:0] now;
        t_in_item    it;
        sent     = 0;
        clock_ms = $urandom;
        while (sent < n_items) begin
            if ($urandom_range(0, 39) == 0) drain();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)      size = $urandom_range(0, 12);
                else if (pick < 95) size = $urandom_range(13, 60);
                else                size = $urandom_range(200, 255);
                if ($urandom_range(0, 49) == 0)      clock_ms = $urandom;
                else if ($urandom_range(0, 9) == 0)  clock_ms += $urandom_range(256, 2000);
                else                                 clock_ms += $urandom_range(0, 30);
                now = ($urandom_range(0, 19) == 0) ? $urandom
                                                   : clock_ms + $urandom_range(0, 150);
                // big samples are always cut short to keep the run brief
                keep = size;
                if (size > 60) keep = $urandom_range(0, 6);
                else if ($urandom_range(0, 9) == 0) keep = $urandom_range(0, size);
                send_header(8'($urandom_range(0, 255)), clock_ms, 8'(size), now);
                sent++;
                repeat (keep) begin
                    send_data(8'($urandom_range(0, 255)));
                    sent++;
                end
            end else if (kind < 80) begin
                send_ctrl(OP_FLUSH, 1'($urandom_range(0, 1)));
                sent++;
            end else if (kind < 90) begin
                send_ctrl(OP_SEND, 1'($urandom_range(0, 1)));
                sent++;
            end else if (kind < 95) begin
                send_data(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                it = noise_beat(t_op'($urandom_range(0, 3)));
                drive_beat(it);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed opening at reset settings: age limit 100, sequence 0
        send_ctrl(OP_FLUSH, 1'b0);                           // flush with nothing buffered
        send_data(8'hFF);                                    // stray payload byte
        send_ctrl(OP_SEND, 1'b0);
        send_ctrl(OP_SEND, 1'b1);                            // sequence moves without a packet
        send_header(8'hFF, 32'hFFFF_FF00, 8'd2, 32'hFFFF_FF00);
        send_data(8'h00);
        send_data(8'hFF);
        send_header(8'h00, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FF63); // delta 255, age 99: stays
        send_header(8'h5A, 32'h0000_0000, 8'd3, 32'hFFFF_FF0A); // delta 256 closes, time wraps
        send_data(8'hC3);
        send_data(8'h3C);
        send_ctrl(OP_FLUSH, 1'b0);                           // sample cut short, zero filled
        send_data(8'h77);                                    // late byte after flush ignored
        send_header(8'h01, 32'd1000, 8'd1, 32'd1000);
        send_data(8'hA5);
        send_header(8'h02, 32'd1010, 8'd0, 32'd1100);        // age reaches the limit
        send_ctrl(OP_FLUSH, 1'b1);
        send_header(8'h03, 32'd2000, 8'd255, 32'hFFFF_FFFF); // oversized first sample dropped
        send_data(8'h12);
        send_data(8'h34);
        send_header(8'h04, 32'd2000, 8'd245, 32'd2000);      // fills the packet exactly
        send_data(8'h11);
        send_header(8'h05, 32'd2001, 8'd0, 32'd2001);        // no room left, full packet out
        send_ctrl(OP_FLUSH, 1'b0);
        send_ctrl(OP_SEND, 1'b1);

        // every header closes, sequence wraps on the first good send
        settle();
        cfg_write(CFG_AGE_LIMIT, 32'h0000_0000);
        cfg_write(CFG_START_SEQ, 32'hA5A5_FFFF);
        cfg_write(CFG_SPARE, $urandom);
        run_traffic(75);

        // age check effectively off
        settle();
        cfg_write(CFG_AGE_LIMIT, 32'hFFFF_FFFF);
        cfg_write(CFG_START_SEQ, 32'h0000_0000);
        run_traffic(90);

        settle();
        cfg_write(CFG_AGE_LIMIT, $urandom_range(20, 300));
        cfg_write(CFG_START_SEQ, $urandom);
        run_traffic(90);

        settle();
        cfg_write(CFG_AGE_LIMIT, 32'd100);
        cfg_write(CFG_START_SEQ, 32'h0000_7FFF);
        run_traffic(90);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.words_due.size() == 0) begin
            $display("[sensor_sample_packet_framer_unit] OK");
        end else begin
            $display("[sensor_sample_packet_framer_unit] ERROR");
        end
        $finish;
    end

endmodule
